@@ design/assert_macros.svh @@
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The expression must hold in every cycle out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: invariant");

`endif

@@ design/terb_pkg.sv @@
`default_nettype none

package terb_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int STAMP_BITS_DEF = 15;
    localparam int ADDR_BITS_DEF  = 6;
    localparam int MATCH_BITS_DEF = 10;

    localparam int DROP_BITS = 5;
    localparam logic [DROP_BITS-1:0] DROP_MAX = '1;

    // Control part of the item context that walks down the slot chain.
    typedef struct packed {
        logic live;    // an item is in this stage
        logic cmd;     // 0 arrival, 1 tick
        logic placed;  // arrival already stored in an earlier slot
        logic busy;    // output taken on this tick or still blocked
        logic ev;      // an event is emitted on this tick
        logic hv;      // holding register full
    } t_ctl;

endpackage

`default_nettype wire

@@ design/timestamped_event_release_buffer.sv @@
// Timestamped event release buffer.
// Items enter on start while busy is low: command 0 is an arriving event
// (now, timestamp, neuron), command 1 is a system clock tick (now).
// Every item gives exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall, so results are never held back.
// Disabled items and expired arrivals are answered directly: o_done rises
// in the cycle after the accepting edge and busy stays low.
// All other items walk down a row of SLOTS cells, one cell per cycle, each
// cell owning one slot. busy is high from the accepting edge until the
// result appears, while the item passes the head register and then the
// register of each cell in turn; the length of the cell row sets this time.
// The holding register and the output-busy flag sit at the head of the
// row and are updated when a tick leaves its end.
// Register enabled (address 0, reset 1) must be written over the APB port
// only while the block is idle; the block does not enforce this. Reset
// empties all slots and the holding register and clears the output-busy flag.
`default_nettype none

`include "assert_macros.svh"

module timestamped_event_release_buffer import terb_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int MATCH_BITS = MATCH_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_command,
    input  wire logic [STAMP_BITS-1:0] i_now,
    input  wire logic [STAMP_BITS-1:0] i_timestamp,
    input  wire logic [ADDR_BITS-1:0]  i_neuron,
    output logic                       o_done,
    output logic                       o_emit_valid,
    output logic [ADDR_BITS-1:0]       o_emit_neuron,
    output logic [1:0]                 o_status,
    output logic [DROP_BITS-1:0]       o_drops,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXPIRED = 2'd1,
        ST_FULL    = 2'd2,
        ST_OFF     = 2'd3
    } t_status;

    localparam logic REG_ENABLED = 1'b0;

    t_ctl                  w_ctl   [SLOTS+1];
    logic [MATCH_BITS-1:0] w_key   [SLOTS+1];
    logic [ADDR_BITS-1:0]  w_nrn   [SLOTS+1];
    logic [ADDR_BITS-1:0]  w_en    [SLOTS+1];
    logic [ADDR_BITS-1:0]  w_hn    [SLOTS+1];
    logic [DROP_BITS-1:0]  w_drops [SLOTS+1];
    logic [SLOTS:0]        w_live;

    logic                  r_enabled;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_held_valid;
    logic [ADDR_BITS-1:0]  r_held_neuron;
    logic                  r_out_busy;
    t_ctl                  r_ctl0;
    t_ctl                  n_ctl0;
    logic [MATCH_BITS-1:0] r_key0;
    logic [ADDR_BITS-1:0]  r_nrn0;
    logic [ADDR_BITS-1:0]  r_en0;
    logic [ADDR_BITS-1:0]  n_en0;
    logic                  r_emit_valid;
    logic [ADDR_BITS-1:0]  r_emit_neuron;
    t_status               r_status;
    logic [DROP_BITS-1:0]  r_drops;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [STAMP_BITS-1:0] w_diff;
    logic                  w_direct;
    logic                  w_take_held;
    t_ctl                  w_tail;
    logic                  w_off_reply;

    assign w_accept    = start && !r_busy;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    // An arrival whose timestamp lies behind now wraps into the upper half.
    assign w_diff      = i_timestamp - i_now;
    assign w_direct    = !r_enabled || (!i_command && w_diff[STAMP_BITS-1]);
    assign w_take_held = i_command && !r_out_busy && r_held_valid;
    assign w_tail      = w_ctl[SLOTS];

    always_comb begin
        n_ctl0.live   = 1'b1;
        n_ctl0.cmd    = i_command;
        n_ctl0.placed = 1'b0;
        n_ctl0.ev     = w_take_held;
        n_ctl0.busy   = r_out_busy || w_take_held;
        n_ctl0.hv     = r_held_valid && !w_take_held;
        n_en0         = w_take_held ? r_held_neuron : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b1;
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_busy   <= 1'b0;
            r_ctl0       <= '0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_ENABLED) begin
                r_enabled <= pwdata[0];
            end
            r_done <= (w_accept && w_direct) || w_tail.live;
            r_ctl0 <= (w_accept && !w_direct) ? n_ctl0 : t_ctl'('0);
            if (w_accept && !w_direct) begin
                r_busy <= 1'b1;
            end else if (w_tail.live) begin
                r_busy <= 1'b0;
            end
            if (w_tail.live && w_tail.cmd) begin
                r_held_valid <= w_tail.hv;
                r_out_busy   <= w_tail.ev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_direct) begin
            r_key0 <= i_command ? i_now[MATCH_BITS-1:0] : i_timestamp[MATCH_BITS-1:0];
            r_nrn0 <= i_neuron;
            r_en0  <= n_en0;
        end
        if (w_tail.live) begin
            r_emit_valid  <= w_tail.ev;
            r_emit_neuron <= w_en[SLOTS];
            r_drops       <= w_drops[SLOTS];
            r_status      <= (w_tail.cmd || w_tail.placed) ? ST_OK : ST_FULL;
            if (w_tail.cmd) begin
                r_held_neuron <= w_hn[SLOTS];
            end
        end else if (w_accept && w_direct) begin
            r_emit_valid  <= 1'b0;
            r_emit_neuron <= '0;
            r_status      <= r_enabled ? ST_EXPIRED : ST_OFF;
            r_drops       <= '0;
        end
    end

    assign w_ctl[0]   = r_ctl0;
    assign w_key[0]   = r_key0;
    assign w_nrn[0]   = r_nrn0;
    assign w_en[0]    = r_en0;
    assign w_hn[0]    = r_held_neuron;
    assign w_drops[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        terb_cell #(
            .MATCH_BITS(MATCH_BITS),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[g]),
            .i_key  (w_key[g]),
            .i_nrn  (w_nrn[g]),
            .i_en   (w_en[g]),
            .i_hn   (w_hn[g]),
            .i_drops(w_drops[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_key  (w_key[g+1]),
            .o_nrn  (w_nrn[g+1]),
            .o_en   (w_en[g+1]),
            .o_hn   (w_hn[g+1]),
            .o_drops(w_drops[g+1])
        );
    end

    for (genvar g = 0; g <= SLOTS; g++) begin : g_live
        assign w_live[g] = w_ctl[g].live;
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_emit_valid  = r_emit_valid;
    assign o_emit_neuron = r_emit_neuron;
    assign o_status      = r_status;
    assign o_drops       = r_drops;
    assign prdata        = (paddr[2] == REG_ENABLED) ? {31'b0, r_enabled} : 32'b0;
    assign pready        = 1'b1;

    assign w_off_reply = r_done && r_status == ST_OFF && !r_emit_valid;

    // At most one item walks the slot chain at a time.
    `ASSERT_ALWAYS(a_one_in_flight, i_clk, i_rst_n, $onehot0(w_live))
    // While the chain holds an item, the block must report busy.
    `ASSERT_SAME(a_busy_while_walk, i_clk, i_rst_n, w_live != '0, r_busy)
    // An emission leaves the output blocked for the next tick.
    `ASSERT_SAME(a_emit_blocks, i_clk, i_rst_n, r_done && r_emit_valid, r_out_busy)
    // A disabled block answers the next cycle with the ignored status.
    `ASSERT_NEXT(a_off_direct, i_clk, i_rst_n, w_accept && !r_enabled, w_off_reply)

endmodule

`default_nettype wire

@@ design/terb_cell.sv @@
`default_nettype none

module terb_cell import terb_pkg::*; #(
    parameter int MATCH_BITS = MATCH_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    input  wire logic [MATCH_BITS-1:0] i_key,
    input  wire logic [ADDR_BITS-1:0]  i_nrn,
    input  wire logic [ADDR_BITS-1:0]  i_en,
    input  wire logic [ADDR_BITS-1:0]  i_hn,
    input  wire logic [DROP_BITS-1:0]  i_drops,
    output t_ctl                       o_ctl,
    output logic [MATCH_BITS-1:0]      o_key,
    output logic [ADDR_BITS-1:0]       o_nrn,
    output logic [ADDR_BITS-1:0]       o_en,
    output logic [ADDR_BITS-1:0]       o_hn,
    output logic [DROP_BITS-1:0]       o_drops
);

    logic                  r_valid;
    logic                  n_valid;
    logic [MATCH_BITS-1:0] r_slot_key;
    logic [ADDR_BITS-1:0]  r_slot_nrn;
    t_ctl                  r_ctl;
    t_ctl                  n_ctl;
    logic [MATCH_BITS-1:0] r_key;
    logic [ADDR_BITS-1:0]  r_nrn;
    logic [ADDR_BITS-1:0]  r_en;
    logic [ADDR_BITS-1:0]  n_en;
    logic [ADDR_BITS-1:0]  r_hn;
    logic [ADDR_BITS-1:0]  n_hn;
    logic [DROP_BITS-1:0]  r_drops;
    logic [DROP_BITS-1:0]  n_drops;
    logic                  w_store;
    logic                  w_hit;

    assign w_hit = r_valid && (r_slot_key == i_key);

    always_comb begin
        n_ctl   = i_ctl;
        n_en    = i_en;
        n_hn    = i_hn;
        n_drops = i_drops;
        n_valid = r_valid;
        w_store = 1'b0;
        if (i_ctl.live) begin
            if (!i_ctl.cmd) begin
                if (!i_ctl.placed && !r_valid) begin
                    n_valid      = 1'b1;
                    w_store      = 1'b1;
                    n_ctl.placed = 1'b1;
                end
            end else if (w_hit) begin
                // A due slot goes to the output, then to the holding register,
                // and is otherwise counted as dropped.
                n_valid = 1'b0;
                if (!i_ctl.busy) begin
                    n_ctl.ev   = 1'b1;
                    n_ctl.busy = 1'b1;
                    n_en       = r_slot_nrn;
                end else if (!i_ctl.hv) begin
                    n_ctl.hv = 1'b1;
                    n_hn     = r_slot_nrn;
                end else if (i_drops != DROP_MAX) begin
                    n_drops = i_drops + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_valid <= n_valid;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_slot_key <= i_key;
            r_slot_nrn <= i_nrn;
        end
        r_key   <= i_key;
        r_nrn   <= i_nrn;
        r_en    <= n_en;
        r_hn    <= n_hn;
        r_drops <= n_drops;
    end

    assign o_ctl   = r_ctl;
    assign o_key   = r_key;
    assign o_nrn   = r_nrn;
    assign o_en    = r_en;
    assign o_hn    = r_hn;
    assign o_drops = r_drops;

endmodule

`default_nettype wire

@@ test/release_scoreboard_pkg.sv @@
package release_scoreboard_pkg;
    import terb_pkg::*;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXPIRED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    localparam logic [2:0] REG_ENABLED = 3'd0;

    typedef struct packed {
        logic                     ev;
        logic [ADDR_BITS_DEF-1:0] nrn;
        logic [1:0]               st;
        logic [DROP_BITS-1:0]     drops;
    } release_t;

    class release_scoreboard;
        bit                      enabled;
        bit                      slot_used [SLOTS_DEF];
        logic [ADDR_BITS_DEF-1:0]  slot_nrn [SLOTS_DEF];
        logic [STAMP_BITS_DEF-1:0] slot_stamp [SLOTS_DEF];
        bit                      held_full;
        logic [ADDR_BITS_DEF-1:0]  held_nrn;
        bit                      out_blocked;
        release_t                due [$];
        int mismatches, checked;
        int arrivals, ticks, stored, expired, full, ignored, releases, dropped;

        function new();
            enabled = 1'b1;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            held_full = 1'b0;
            out_blocked = 1'b0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Works out the result of one accepted item and advances the buffer state.
        function void note_item(logic cmd, logic [STAMP_BITS_DEF-1:0] now,
                                logic [STAMP_BITS_DEF-1:0] stamp,
                                logic [ADDR_BITS_DEF-1:0] nrn);
            release_t want;
            logic [STAMP_BITS_DEF-1:0] ahead;
            bit lock_free;
            int free_idx;
            want = '0;
            want.st = ST_OK;
            if (!enabled) begin
                want.st = ST_DISABLED;
                ignored++;
            end else if (cmd == CMD_ARRIVE) begin
                arrivals++;
                ahead = stamp - now;
                free_idx = -1;
                for (int i = SLOTS_DEF - 1; i >= 0; i--)
                    if (!slot_used[i]) free_idx = i;
                if (ahead[STAMP_BITS_DEF-1]) begin
                    want.st = ST_EXPIRED;
                    expired++;
                end else if (free_idx < 0) begin
                    want.st = ST_FULL;
                    full++;
                end else begin
                    slot_used[free_idx] = 1'b1;
                    slot_nrn[free_idx] = nrn;
                    slot_stamp[free_idx] = stamp;
                    stored++;
                end
            end else begin
                ticks++;
                lock_free = 1'b1;
                if (!out_blocked && held_full) begin
                    want.ev = 1'b1;
                    want.nrn = held_nrn;
                    held_full = 1'b0;
                    out_blocked = 1'b1;
                    lock_free = 1'b0;
                end
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (slot_used[i] &&
                        slot_stamp[i][MATCH_BITS_DEF-1:0] == now[MATCH_BITS_DEF-1:0]) begin
                        slot_used[i] = 1'b0;
                        if (!out_blocked) begin
                            want.ev = 1'b1;
                            want.nrn = slot_nrn[i];
                            out_blocked = 1'b1;
                            lock_free = 1'b0;
                        end else if (!held_full) begin
                            held_nrn = slot_nrn[i];
                            held_full = 1'b1;
                        end else if (want.drops != DROP_MAX) begin
                            want.drops = want.drops + 1'b1;
                        end
                    end
                end
                if (lock_free) out_blocked = 1'b0;
                if (want.ev) releases++;
                dropped += want.drops;
            end
            due.push_back(want);
        endfunction

        function void check_result(release_t got);
            release_t want;
            checked++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d arrived with no item waiting for it",
                             $time, checked);
                return;
            end
            want = due.pop_front();
            if (got.ev !== want.ev || got.nrn !== want.nrn || got.st !== want.st ||
                got.drops !== want.drops) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: result %0d expected valid=%0b neuron=%0d status=%0d drops=%0d",
                           $time, checked, want.ev, want.nrn, want.st, want.drops);
                    $display(", got valid=%0b neuron=%0d status=%0d drops=%0d",
                             got.ev, got.nrn, got.st, got.drops);
                end
            end
        endfunction

        function void close_out();
            if (due.size() != 0) begin
                $display("%0d expected results never arrived", due.size());
                mismatches += due.size();
            end
        endfunction
    endclass

endpackage

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import terb_pkg::*;
    import release_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = SLOTS_DEF + 4;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      i_command = CMD_TICK;
    logic [STAMP_BITS_DEF-1:0] i_now = '0;
    logic [STAMP_BITS_DEF-1:0] i_timestamp = '0;
    logic [ADDR_BITS_DEF-1:0]  i_neuron = '0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [2:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic                      busy;
    logic                      o_done;
    logic                      o_emit_valid;
    logic [ADDR_BITS_DEF-1:0]  o_emit_neuron;
    logic [1:0]                o_status;
    logic [DROP_BITS-1:0]      o_drops;
    logic [31:0]               prdata;
    logic                      pready;

    release_scoreboard         book;
    logic [STAMP_BITS_DEF-1:0] sys_now;
    int                        quiet_cycles = 0;

    timestamped_event_release_buffer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_now(i_now), .i_timestamp(i_timestamp),
        .i_neuron(i_neuron), .o_done(o_done), .o_emit_valid(o_emit_valid),
        .o_emit_neuron(o_emit_neuron), .o_status(o_status), .o_drops(o_drops),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : result_monitor
        release_t got;
        if (i_rst_n && o_done) begin
            got.ev = o_emit_valid;
            got.nrn = o_emit_neuron;
            got.st = o_status;
            got.drops = o_drops;
            book.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called on a rising edge; returns on the edge that accepted the item,
    // with start still high so the next item can follow at once.
    task automatic send_item(input logic cmd, input logic [STAMP_BITS_DEF-1:0] now,
                             input logic [STAMP_BITS_DEF-1:0] stamp,
                             input logic [ADDR_BITS_DEF-1:0] nrn);
        start <= 1'b1;
        i_command <= cmd;
        i_now <= now;
        i_timestamp <= stamp;
        i_neuron <= nrn;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book.note_item(cmd, now, stamp, nrn);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_ENABLED;
        pwdata <= {31'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        book.enabled = value;
        @(posedge i_clk);
    endtask

    // Mostly a coherent stream: ticks walk the system time forward and
    // arrivals land a few ticks ahead, so slots fill, match and collide.
    task automatic random_item();
        int pick;
        int kind;
        logic [STAMP_BITS_DEF-1:0] stamp;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 49) == 0) sys_now = STAMP_BITS_DEF'($urandom);
            send_item(CMD_TICK, sys_now, STAMP_BITS_DEF'($urandom),
                      ADDR_BITS_DEF'($urandom));
            sys_now = sys_now + 1'b1;
        end else if (pick < 80) begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                stamp = sys_now + STAMP_BITS_DEF'($urandom_range(0, 3));
            else if (kind < 8)
                stamp = sys_now + STAMP_BITS_DEF'($urandom_range(0, 15));
            else
                stamp = sys_now + STAMP_BITS_DEF'($urandom_range(0, 15)) +
                        STAMP_BITS_DEF'($urandom_range(1, 14) << MATCH_BITS_DEF);
            send_item(CMD_ARRIVE, sys_now, stamp, ADDR_BITS_DEF'($urandom));
        end else if (pick < 90) begin
            stamp = sys_now - STAMP_BITS_DEF'($urandom_range(1, 16384));
            send_item(CMD_ARRIVE, sys_now, stamp, ADDR_BITS_DEF'($urandom));
        end else begin
            send_item(1'($urandom), STAMP_BITS_DEF'($urandom), STAMP_BITS_DEF'($urandom),
                      ADDR_BITS_DEF'($urandom));
        end
    endtask

    initial begin
        int count;
        bit bursty;
        book = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part: wrap of the time window, expiry edge, holding register
        // refill, a blocked output, a full buffer and a large drop count.
        send_item(CMD_ARRIVE, 15'd0, 15'd0, 6'd63);
        send_item(CMD_ARRIVE, 15'd0, 15'h4000, 6'd1);
        send_item(CMD_ARRIVE, 15'd0, 15'h3fff, 6'd2);
        send_item(CMD_ARRIVE, 15'h7fff, 15'd0, 6'd3);
        send_item(CMD_ARRIVE, 15'd0, 15'd2, 6'd4);
        send_item(CMD_TICK, 15'd0, 15'd0, 6'd0);
        send_item(CMD_TICK, 15'd1, 15'h7fff, 6'd63);
        send_item(CMD_TICK, 15'd2, 15'd0, 6'd0);
        send_item(CMD_TICK, 15'd3, 15'd0, 6'd0);
        for (int i = 0; i < SLOTS_DEF; i++)
            send_item(CMD_ARRIVE, 15'd3, 15'd5, ADDR_BITS_DEF'(i + 10));
        send_item(CMD_TICK, 15'd4, 15'd0, 6'd0);
        send_item(CMD_TICK, 15'd5, 15'd0, 6'd0);
        send_item(CMD_TICK, 15'd6, 15'd0, 6'd0);
        send_item(CMD_TICK, 15'h3ff, 15'd0, 6'd0);
        drain();
        write_enable(1'b0);
        send_item(CMD_ARRIVE, 15'd10, 15'd12, 6'd7);
        send_item(CMD_TICK, 15'h7fff, 15'h7fff, 6'd63);
        drain();

        sys_now = STAMP_BITS_DEF'($urandom);
        for (int p = 0; p < 6; p++) begin
            drain();
            write_enable(p != 2);
            count = (p == 2) ? 60 : 180;
            bursty = 1'b0;
            for (int k = 0; k < count; k++) begin
                // The last phase runs back to back to stress the full rate.
                if (k % 40 == 0) bursty = (p < 5) && ($urandom_range(0, 2) != 0);
                random_item();
                if (bursty && $urandom_range(0, 4) == 0)
                    pause($urandom_range(1, 8));
                else if (p < 5 && $urandom_range(0, 149) == 0)
                    drain();
            end
        end
        drain();
        book.close_out();

        $display("Covered %0d ticks and %0d arrivals (%0d stored, %0d expired, %0d full)",
                 book.ticks, book.arrivals, book.stored, book.expired, book.full);
        $display("with %0d items ignored while disabled, %0d releases, %0d drops, %0d mismatches",
                 book.ignored, book.releases, book.dropped, book.mismatches);
        if (book.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
